FILE: design/mprfs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mprfs_pkg
// Shared codes, field widths and beat layouts of the pattern scanner.
// ============================================================================
package mprfs_pkg;

    // Item function codes (carried on s_tuser)
    localparam logic [1:0] FUNC_STORE  = 2'd0;
    localparam logic [1:0] FUNC_DEFINE = 2'd1;
    localparam logic [1:0] FUNC_TEXT   = 2'd2;
    localparam logic [1:0] FUNC_END    = 2'd3;

    // Byte that closes a text line
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    localparam int CFG_W     = 4;
    localparam int LINE_W    = 20;
    localparam int COL_W     = 16;
    localparam int CNT_W     = 16;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 80;

    // Input beat payload, last field in the lowest bits
    typedef struct packed {
        logic [4:0] pattern_length;
        logic       rule_severity;
        logic       rule_kind;
        logic [7:0] byte_value;
        logic [3:0] char_position;
        logic [2:0] rule_slot;
    } in_beat_t;

    // Result beat payload, last field in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]  warning_total;
        logic [CNT_W-1:0]  error_total;
        logic [COL_W-1:0]  column;
        logic [LINE_W-1:0] line_number;
        logic              hit_severity;
        logic              hit_kind;
        logic [2:0]        hit_rule;
    } res_beat_t;

    localparam int RES_W = $bits(res_beat_t);

endpackage

FILE: design/mprfs_match.sv
`timescale 1ns / 1ps
// ============================================================================
// mprfs_match
// Rule tables, text window and parallel comparison; builds one job per
// item that has results (forbid hits of a byte, or end-of-text report).
// ============================================================================
module mprfs_match
    import mprfs_pkg::*;
#(
    parameter int NUM_RULES   = 8,
    parameter int PATTERN_LEN = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   in_fire,
    input  logic [1:0]             in_func,
    input  in_beat_t               in_beat,
    output logic                   in_ready,
    output logic                   job_valid,
    input  logic                   job_ready,
    output logic                   job_end,
    output logic [NUM_RULES-1:0]   job_mask,
    output logic [NUM_RULES-1:0]   job_sev,
    output logic [COL_W-1:0]       job_col [NUM_RULES],
    output logic [LINE_W-1:0]      job_line
);

    localparam int LEN_W = $clog2(PATTERN_LEN + 1);
    localparam int IDX_W = $clog2(PATTERN_LEN);
    localparam int HIST  = PATTERN_LEN - 1;

    // Rule tables
    logic [7:0]       pat_reg [NUM_RULES][PATTERN_LEN];
    logic [LEN_W-1:0] len_reg [NUM_RULES];
    logic [NUM_RULES-1:0] kind_reg;
    logic [NUM_RULES-1:0] sev_reg;
    logic [CFG_W-1:0] rules_in_use_reg;

    // Text state
    logic [7:0]          recent_reg [HIST];
    logic [COL_W-1:0]    bil_reg;
    logic [LINE_W-1:0]   line_reg;
    logic [NUM_RULES-1:0] seen_reg;

    // Job register
    logic                 job_valid_reg;
    logic                 job_end_reg;
    logic [NUM_RULES-1:0] job_mask_reg;
    logic [NUM_RULES-1:0] job_sev_reg;
    logic [COL_W-1:0]     job_col_reg [NUM_RULES];
    logic [LINE_W-1:0]    job_line_reg;

    logic [7:0]           win [PATTERN_LEN];
    logic [COL_W-1:0]     bil_next;
    logic [NUM_RULES-1:0] active;
    logic [NUM_RULES-1:0] match;
    logic [NUM_RULES-1:0] missing;
    logic [COL_W-1:0]     col_calc [NUM_RULES];
    logic [LEN_W-1:0]     win_idx;
    logic                 is_text;
    logic                 is_nl;
    logic [4:0]           plen_sat;
    logic                 job_new;

    assign in_ready = !job_valid_reg || job_ready;

    assign is_text = (in_func == FUNC_TEXT);
    assign is_nl   = (in_beat.byte_value == NEWLINE_BYTE);
    assign bil_next = (bil_reg == '1) ? bil_reg : bil_reg + COL_W'(1);
    assign plen_sat = (32'(in_beat.pattern_length) > PATTERN_LEN)
                    ? 5'(PATTERN_LEN) : in_beat.pattern_length;

    // Window ending at the incoming byte
    always_comb
    begin
        win[0] = in_beat.byte_value;
        for (int i = 1; i < PATTERN_LEN; i++)
        begin
            win[i] = recent_reg[i-1];
        end
    end

    // Parallel window compare, one lane per rule
    always_comb
    begin
        win_idx = '0;
        for (int r = 0; r < NUM_RULES; r++)
        begin
            active[r] = 32'(rules_in_use_reg) > r;
            match[r]  = (len_reg[r] != '0) && (bil_next >= COL_W'(len_reg[r]));
            for (int k = 0; k < PATTERN_LEN; k++)
            begin
                win_idx = len_reg[r] - LEN_W'(k) - LEN_W'(1);
                if (32'(len_reg[r]) > k)
                begin
                    if (pat_reg[r][k] != win[win_idx[IDX_W-1:0]])
                    begin
                        match[r] = 1'b0;
                    end
                end
            end
            col_calc[r] = (bil_next == '1) ? bil_next
                        : bil_next - COL_W'(len_reg[r]) + COL_W'(1);
            missing[r] = active[r] && !kind_reg[r]
                       && !((len_reg[r] != '0) && seen_reg[r]);
        end
    end

    assign job_new = in_fire
                   && ((in_func == FUNC_END)
                       || (is_text && !is_nl && |(match & active & kind_reg)));

    // Pattern characters: no reset, undefined until written
    always_ff @(posedge clk)
    begin
        if (in_fire && in_func == FUNC_STORE)
        begin
            for (int r = 0; r < NUM_RULES; r++)
            begin
                for (int k = 0; k < PATTERN_LEN; k++)
                begin
                    if (32'(in_beat.rule_slot) == r && 32'(in_beat.char_position) == k)
                    begin
                        pat_reg[r][k] <= in_beat.byte_value;
                    end
                end
            end
        end
    end

    // Job payload
    always_ff @(posedge clk)
    begin
        if (job_new)
        begin
            job_end_reg  <= (in_func == FUNC_END);
            job_mask_reg <= (in_func == FUNC_END) ? missing : (match & active & kind_reg);
            job_sev_reg  <= sev_reg;
            job_line_reg <= line_reg;
            for (int r = 0; r < NUM_RULES; r++)
            begin
                job_col_reg[r] <= col_calc[r];
            end
        end
    end

    // Rule tables, text state and job valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rules_in_use_reg <= '0;
            kind_reg         <= '0;
            sev_reg          <= '0;
            seen_reg         <= '0;
            bil_reg          <= '0;
            line_reg         <= LINE_W'(1);
            job_valid_reg    <= 1'b0;
            for (int r = 0; r < NUM_RULES; r++)
            begin
                len_reg[r] <= '0;
            end
            for (int i = 0; i < HIST; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                rules_in_use_reg <= cfg_wdata;
            end

            if (job_new)
            begin
                job_valid_reg <= 1'b1;
            end
            else if (job_ready)
            begin
                job_valid_reg <= 1'b0;
            end

            if (in_fire)
            begin
                case (in_func)
                    FUNC_DEFINE:
                    begin
                        for (int r = 0; r < NUM_RULES; r++)
                        begin
                            if (32'(in_beat.rule_slot) == r)
                            begin
                                len_reg[r]  <= LEN_W'(plen_sat);
                                kind_reg[r] <= in_beat.rule_kind;
                                sev_reg[r]  <= in_beat.rule_severity;
                                seen_reg[r] <= 1'b0;
                            end
                        end
                    end
                    FUNC_TEXT:
                    begin
                        if (is_nl)
                        begin
                            if (line_reg != '1)
                            begin
                                line_reg <= line_reg + LINE_W'(1);
                            end
                            bil_reg <= '0;
                        end
                        else
                        begin
                            for (int i = 0; i < HIST; i++)
                            begin
                                recent_reg[i] <= win[i];
                            end
                            bil_reg  <= bil_next;
                            seen_reg <= seen_reg | (match & active & ~kind_reg);
                        end
                    end
                    FUNC_END:
                    begin
                        for (int i = 0; i < HIST; i++)
                        begin
                            recent_reg[i] <= '0;
                        end
                        bil_reg  <= '0;
                        line_reg <= LINE_W'(1);
                        seen_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign job_valid = job_valid_reg;
    assign job_end   = job_end_reg;
    assign job_mask  = job_mask_reg;
    assign job_sev   = job_sev_reg;
    assign job_col   = job_col_reg;
    assign job_line  = job_line_reg;

endmodule

FILE: design/mprfs_emit.sv
`timescale 1ns / 1ps
// ============================================================================
// mprfs_emit
// Drains one job a result beat at a time, lowest rule first, keeps the
// error and warning totals and holds the output register.
// ============================================================================
module mprfs_emit
    import mprfs_pkg::*;
#(
    parameter int NUM_RULES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  logic                 job_end,
    input  logic [NUM_RULES-1:0] job_mask,
    input  logic [NUM_RULES-1:0] job_sev,
    input  logic [COL_W-1:0]     job_col [NUM_RULES],
    input  logic [LINE_W-1:0]    job_line,
    output logic                 out_valid,
    input  logic                 out_ready,
    output res_beat_t            out_res,
    output logic                 out_totals,
    output logic                 out_last
);

    localparam int RULE_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;

    // Working copy of the job
    logic                 act_reg;
    logic                 end_reg;
    logic [NUM_RULES-1:0] mask_reg;
    logic [NUM_RULES-1:0] sev_reg;
    logic [COL_W-1:0]     col_reg [NUM_RULES];
    logic [LINE_W-1:0]    line_reg;

    logic [CNT_W-1:0]     err_reg;
    logic [CNT_W-1:0]     warn_reg;

    logic                 out_valid_reg;
    res_beat_t            res_reg;
    logic                 totals_reg;
    logic                 last_reg;

    logic                 out_free;
    logic                 emit;
    logic                 have_hit;
    logic [NUM_RULES-1:0] low_bit;
    logic [NUM_RULES-1:0] mask_rest;
    logic [RULE_W-1:0]    sel;
    logic                 finishing;
    logic                 hit_sev;
    logic [CNT_W-1:0]     err_next;
    logic [CNT_W-1:0]     warn_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = act_reg && out_free;
    assign have_hit  = (mask_reg != '0);
    assign low_bit   = mask_reg & (~mask_reg + NUM_RULES'(1));
    assign mask_rest = mask_reg & ~low_bit;
    assign finishing = !have_hit || ((mask_rest == '0) && !end_reg);
    assign job_ready = !act_reg || (out_free && finishing);

    // Lowest pending rule
    always_comb
    begin
        sel = '0;
        for (int r = NUM_RULES - 1; r >= 0; r--)
        begin
            if (mask_reg[r])
            begin
                sel = RULE_W'(r);
            end
        end
    end

    // Saturating totals including the reported issue
    always_comb
    begin
        hit_sev   = sev_reg[sel];
        err_next  = err_reg;
        warn_next = warn_reg;
        if (hit_sev)
        begin
            if (err_reg != '1)
            begin
                err_next = err_reg + CNT_W'(1);
            end
        end
        else if (warn_reg != '1)
        begin
            warn_next = warn_reg + CNT_W'(1);
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            end_reg  <= job_end;
            mask_reg <= job_mask;
            sev_reg  <= job_sev;
            col_reg  <= job_col;
            line_reg <= job_line;
        end
        else if (emit && have_hit)
        begin
            mask_reg <= mask_rest;
        end

        if (emit)
        begin
            if (have_hit)
            begin
                res_reg.hit_rule     <= 3'(sel);
                res_reg.hit_kind     <= !end_reg;
                res_reg.hit_severity <= hit_sev;
                res_reg.line_number  <= end_reg ? '0 : line_reg;
                res_reg.column       <= end_reg ? '0 : col_reg[sel];
                res_reg.error_total  <= err_next;
                res_reg.warning_total <= warn_next;
                totals_reg           <= 1'b0;
                last_reg             <= (mask_rest == '0) && !end_reg;
            end
            else
            begin
                res_reg.hit_rule     <= '0;
                res_reg.hit_kind     <= 1'b0;
                res_reg.hit_severity <= 1'b0;
                res_reg.line_number  <= '0;
                res_reg.column       <= '0;
                res_reg.error_total  <= err_reg;
                res_reg.warning_total <= warn_reg;
                totals_reg           <= 1'b1;
                last_reg             <= 1'b1;
            end
        end
    end

    // Control: job activity, totals and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            err_reg       <= '0;
            warn_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid && job_ready)
            begin
                act_reg <= 1'b1;
            end
            else if (emit && finishing)
            begin
                act_reg <= 1'b0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
                if (have_hit)
                begin
                    err_reg  <= err_next;
                    warn_reg <= warn_next;
                end
                else
                begin
                    err_reg  <= '0;
                    warn_reg <= '0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_res    = res_reg;
    assign out_totals = totals_reg;
    assign out_last   = last_reg;

endmodule

FILE: design/multi_pattern_require_forbid_scanner_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_pattern_require_forbid_scanner_unit
// Require/forbid byte pattern scanner over a streamed text.
// ============================================================================
// Usage:
//   Slave stream: s_tuser carries the item function (store pattern char,
//   define rule, text byte, end of text), s_tdata the item fields.
//   Master stream: one beat per forbid occurrence, per missing require rule
//   and per end-of-text totals; m_tlast marks the final beat of an item,
//   m_tuser marks the totals beat.
//   cfg_we/cfg_wdata write the number of rule slots in use; write it only
//   while no item is in flight.
// Timing:
//   A beat whose item has results passes the job register, the serialiser's
//   working copy and the output register. One item is taken per cycle while
//   each causes at most one result and m_tready is high; an item with
//   several results occupies the result serialiser for one beat each, and
//   the single job register before the serialiser then holds back s_tready.
// Reset:
//   Rule tables, totals and text position clear at once; pattern characters
//   are undefined until stored. No clearing pass.
// Stall:
//   A stalled m_tready holds the output register; the serialiser and then
//   the job register fill, after which s_tready drops. No beat is lost.
// ============================================================================
module multi_pattern_require_forbid_scanner_unit
    import mprfs_pkg::*;
#(
    parameter int NUM_RULES   = 8,
    parameter int PATTERN_LEN = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,      // rules_in_use
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // rule_slot[2:0], char_position[6:3], byte_value[14:7], rule_kind[15],
    // rule_severity[16], pattern_length[21:17], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,        // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit_rule[2:0], hit_kind[3], hit_severity[4], line_number[24:5],
    // column[40:25], error_total[56:41], warning_total[72:57], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]            m_tuser,        // is_totals
    output logic                  m_tlast
);

    logic                 in_fire;
    in_beat_t             in_beat;
    logic                 job_valid;
    logic                 job_ready;
    logic                 job_end;
    logic [NUM_RULES-1:0] job_mask;
    logic [NUM_RULES-1:0] job_sev;
    logic [COL_W-1:0]     job_col [NUM_RULES];
    logic [LINE_W-1:0]    job_line;
    res_beat_t            out_res;
    logic                 out_totals;

    assign in_fire = s_tvalid && s_tready;
    assign in_beat = in_beat_t'(s_tdata[$bits(in_beat_t)-1:0]);

    // Compare stage and rule state
    mprfs_match #(
        .NUM_RULES   (NUM_RULES),
        .PATTERN_LEN (PATTERN_LEN)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_func   (s_tuser),
        .in_beat   (in_beat),
        .in_ready  (s_tready),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_end   (job_end),
        .job_mask  (job_mask),
        .job_sev   (job_sev),
        .job_col   (job_col),
        .job_line  (job_line)
    );

    // Result serialiser and output register
    mprfs_emit #(
        .NUM_RULES (NUM_RULES)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job_end    (job_end),
        .job_mask   (job_mask),
        .job_sev    (job_sev),
        .job_col    (job_col),
        .job_line   (job_line),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res),
        .out_totals (out_totals),
        .out_last   (m_tlast)
    );

    assign m_tdata    = {(OUT_DATA_W - RES_W)'(0), out_res};
    assign m_tuser[0] = out_totals;

endmodule
